/* hdl/porq_pkg.sv */
// ----------------------------------------------------------------------------
// porq_pkg
// Shared types and codes for the policy ordered request queue.
// ----------------------------------------------------------------------------
package porq_pkg;

    localparam logic       REQ_ENQ = 1'b0;
    localparam logic       REQ_DEQ = 1'b1;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_RFF  = 2'd1;
    localparam logic [1:0] POL_SFF  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic       CFG_POLICY   = 1'b0;
    localparam logic       CFG_CAPACITY = 1'b1;

    localparam logic [4:0] CAPACITY_RESET = 5'd4;

    typedef struct packed {
        logic        req_type;
        logic [15:0] request_id;
        logic [31:0] modified_time;
        logic [31:0] item_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] head_id;
        logic        is_full;
        logic        is_empty;
    } t_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] mtime;
        logic [31:0] size;
    } t_entry;

    typedef struct packed {
        logic       enq;
        logic       deq;
        logic [1:0] policy;
    } t_cell_ctrl;

endpackage

/* hdl/porq_if.sv */
// ----------------------------------------------------------------------------
// porq_req_if / porq_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface porq_req_if;
    logic          valid;
    logic          ready;
    porq_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface porq_rsp_if;
    logic          valid;
    logic          ready;
    porq_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/porq_cell.sv */
// ----------------------------------------------------------------------------
// porq_cell
// One queue slot: holds an entry, compares it with the incoming key and
// takes its own value, the new entry or a neighbor's entry each cycle.
// ----------------------------------------------------------------------------
module porq_cell (
    input  logic                  i_clk,
    input  porq_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_live,
    input  logic                  i_before,
    input  porq_pkg::t_entry      i_new,
    input  porq_pkg::t_entry      i_prev,
    input  porq_pkg::t_entry      i_next,
    output porq_pkg::t_entry      o_entry,
    output logic                  o_pass
);

    porq_pkg::t_entry r_entry;
    porq_pkg::t_entry n_entry;
    logic             w_order_ok;

    always_comb begin
        case (i_ctrl.policy)
            porq_pkg::POL_RFF: w_order_ok = (r_entry.mtime >= i_new.mtime);
            porq_pkg::POL_SFF: w_order_ok = (r_entry.size <= i_new.size);
            default:           w_order_ok = 1'b1;
        endcase
    end

    assign o_pass = i_live & w_order_ok;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.deq) begin
            n_entry = i_next;
        end else if (i_ctrl.enq) begin
            if (i_before) begin
                n_entry = i_prev;
            end else if (!o_pass) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* hdl/policy_ordered_request_queue.sv */
// ----------------------------------------------------------------------------
// policy_ordered_request_queue
// Bounded request queue kept in FIFO, recent-first or smallest-first order.
// ----------------------------------------------------------------------------
// Requests arrive on i_req: an enqueue carries an id, a modification time and
// a size; a dequeue removes the head. Every transaction on i_req yields one
// transaction on o_rsp with a status, the removed id and full/empty flags.
// The queue is a row of QUEUE_DEPTH cells, head first. Each cell compares its
// entry with the incoming key in parallel, so an insert or removal needs no
// search: a response is registered in the cycle after its request, and a new
// request is taken every cycle while the response register can drain. When
// o_rsp stalls, the pending response holds and i_req.ready drops until it is
// taken. Reset clears the occupancy, sets the policy to FIFO and the capacity
// to four; entry storage is not cleared. A capacity above QUEUE_DEPTH acts as
// QUEUE_DEPTH. Write the configuration port (i_cfg_we, i_cfg_idx, i_cfg_data)
// only while the queue is idle: the user must see to it, the block does not.
// ----------------------------------------------------------------------------
module policy_ordered_request_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    porq_req_if.sink   i_req,
    porq_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [4:0] i_cfg_data
);

    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (OW > 5) ? OW : 5;

    logic [1:0]        r_policy;
    logic [4:0]        r_cap;
    logic [OW-1:0]     r_occ;
    logic [OW-1:0]     n_occ;
    logic              r_rsp_valid;
    porq_pkg::t_rsp    r_rsp;
    porq_pkg::t_rsp    n_rsp;

    logic              w_accept;
    logic              w_full_now;
    logic [LW-1:0]     w_cap_ext;
    logic [LW-1:0]     w_lim;
    porq_pkg::t_cell_ctrl w_ctrl;
    porq_pkg::t_entry  w_new;
    porq_pkg::t_entry  w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_pass;
    logic [QUEUE_DEPTH-1:0] w_before;
    logic [QUEUE_DEPTH-1:0] w_live;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_cap_ext  = LW'(r_cap);
    assign w_lim      = (w_cap_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : w_cap_ext;
    assign w_full_now = (LW'(r_occ) >= w_lim);

    assign w_new.id    = i_req.payload.request_id;
    assign w_new.mtime = i_req.payload.modified_time;
    assign w_new.size  = i_req.payload.item_size;

    assign w_ctrl.enq    = w_accept && (i_req.payload.req_type == porq_pkg::REQ_ENQ)
                           && !w_full_now;
    assign w_ctrl.deq    = w_accept && (i_req.payload.req_type == porq_pkg::REQ_DEQ)
                           && (r_occ != '0);
    assign w_ctrl.policy = r_policy;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        localparam logic [QUEUE_DEPTH-1:0] LOW_MASK =
            (QUEUE_DEPTH'(1) << g) - QUEUE_DEPTH'(1);
        porq_pkg::t_entry w_prev;
        porq_pkg::t_entry w_next;

        assign w_live[g]   = (OW'(g) < r_occ);
        assign w_before[g] = |(~w_pass & LOW_MASK);

        if (g == 0) begin : g_first
            assign w_prev = w_new;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        porq_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_live   (w_live[g]),
            .i_before (w_before[g]),
            .i_new    (w_new),
            .i_prev   (w_prev),
            .i_next   (w_next),
            .o_entry  (w_entry[g]),
            .o_pass   (w_pass[g])
        );
    end

    always_comb begin
        n_occ          = r_occ;
        n_rsp.status   = porq_pkg::ST_DONE;
        n_rsp.head_id  = '0;
        if (i_req.payload.req_type == porq_pkg::REQ_ENQ) begin
            if (w_full_now) begin
                n_rsp.status = porq_pkg::ST_FULL;
            end else begin
                n_occ = OW'(r_occ + 1'b1);
            end
        end else begin
            if (r_occ == '0) begin
                n_rsp.status = porq_pkg::ST_EMPTY;
            end else begin
                n_rsp.head_id = w_entry[0].id;
                n_occ         = OW'(r_occ - 1'b1);
            end
        end
        n_rsp.is_full  = (LW'(n_occ) >= w_lim);
        n_rsp.is_empty = (n_occ == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
            r_policy    <= porq_pkg::POL_FIFO;
            r_cap       <= porq_pkg::CAPACITY_RESET;
        end else begin
            if (w_accept) begin
                r_occ       <= n_occ;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    porq_pkg::CFG_POLICY:   r_policy <= i_cfg_data[1:0];
                    porq_pkg::CFG_CAPACITY: r_cap    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.deq |=> (r_occ == OW'($past(r_occ) - 1'b1)))
        else $error("dequeue did not lower occupancy");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.enq |=> (r_occ == OW'($past(r_occ) + 1'b1)))
        else $error("enqueue did not raise occupancy");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_rsp_valid)
        else $error("accepted request produced no response");

    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_rsp.status != porq_pkg::ST_DONE)) |-> (r_rsp.head_id == '0))
        else $error("head id set on a failed request");

endmodule

/* dv/tb_policy_ordered_request_queue.sv */
// ----------------------------------------------------------------------------
// tb_policy_ordered_request_queue
// Self-checking testbench for the policy ordered request queue.
// ----------------------------------------------------------------------------
// A scoreboard keeps a shadow copy of the queue contents, policy and capacity.
// It predicts the response of every accepted request transaction and compares
// each accepted response transaction with the oldest prediction. A short
// directed sequence covers the full, empty, tie and odd-register cases. It is
// followed by random phases that sweep the policies and capacities while both
// channels idle and stall.
// ----------------------------------------------------------------------------
module tb_policy_ordered_request_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QUEUE_DEPTH     = 16;
    localparam int         PHASES          = 16;
    localparam int         ITEMS_PER_PHASE = 125;
    localparam int         LONG_HOLD       = 150;
    localparam int         QUIET_LIMIT     = 2000;
    localparam logic [1:0] POL_UNUSED      = 2'd3;

    localparam int MODE_NONE   = 0;
    localparam int MODE_SENDER = 1;
    localparam int MODE_RECV   = 2;
    localparam int MODE_BOTH   = 3;

    class order_scoreboard;
        logic [1:0]        policy;
        logic [4:0]        capacity;
        porq_pkg::t_entry  shadow_entries [QUEUE_DEPTH];
        int unsigned       shadow_count;
        porq_pkg::t_rsp    pending_rsps [$];
        int                errors;
        int                n_requests;
        int                n_rejected;
        int                n_empty_deq;
        int                n_removed;

        function new();
            policy       = porq_pkg::POL_FIFO;
            capacity     = porq_pkg::CAPACITY_RESET;
            shadow_count = 0;
            errors       = 0;
            n_requests   = 0;
            n_rejected   = 0;
            n_empty_deq  = 0;
            n_removed    = 0;
        endfunction

        function void write_register(logic idx, logic [4:0] data);
            if (idx == porq_pkg::CFG_POLICY) begin
                policy = data[1:0];
            end else begin
                capacity = data;
            end
        endfunction

        function void note_request(porq_pkg::t_req r);
            porq_pkg::t_rsp rsp;
            int unsigned    lim;
            int unsigned    slot;
            int unsigned    i;
            rsp = '0;
            lim = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity;
            n_requests++;
            if (r.req_type == porq_pkg::REQ_ENQ) begin
                if (shadow_count >= lim) begin
                    rsp.status = porq_pkg::ST_FULL;
                    n_rejected++;
                end else begin
                    slot = 0;
                    if (policy == porq_pkg::POL_RFF) begin
                        while (slot < shadow_count &&
                               shadow_entries[slot].mtime >= r.modified_time)
                            slot++;
                    end else if (policy == porq_pkg::POL_SFF) begin
                        while (slot < shadow_count &&
                               shadow_entries[slot].size <= r.item_size)
                            slot++;
                    end else begin
                        slot = shadow_count;
                    end
                    for (i = shadow_count; i > slot; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[slot].id    = r.request_id;
                    shadow_entries[slot].mtime = r.modified_time;
                    shadow_entries[slot].size  = r.item_size;
                    shadow_count++;
                end
            end else begin
                if (shadow_count == 0) begin
                    rsp.status = porq_pkg::ST_EMPTY;
                    n_empty_deq++;
                end else begin
                    rsp.head_id = shadow_entries[0].id;
                    for (i = 0; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                    n_removed++;
                end
            end
            rsp.is_full  = (shadow_count >= lim);
            rsp.is_empty = (shadow_count == 0);
            pending_rsps.push_back(rsp);
        endfunction

        function void check_response(porq_pkg::t_rsp got);
            porq_pkg::t_rsp exp;
            if (pending_rsps.size() == 0) begin
                $error("Response transaction arrived with no request outstanding.");
                errors++;
                return;
            end
            exp = pending_rsps.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.head_id !== exp.head_id) begin
                $error("head_id: expected 0x%04h, got 0x%04h", exp.head_id, got.head_id);
                errors++;
            end
            if (got.is_full !== exp.is_full) begin
                $error("is_full: expected %0b, got %0b", exp.is_full, got.is_full);
                errors++;
            end
            if (got.is_empty !== exp.is_empty) begin
                $error("is_empty: expected %0b, got %0b", exp.is_empty, got.is_empty);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [4:0] i_cfg_data;

    porq_req_if req_if ();
    porq_rsp_if rsp_if ();

    policy_ordered_request_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    order_scoreboard sb;
    int              idle_mode      = MODE_NONE;
    int              stall_requests = 0;
    int              stall_served   = 0;
    int              hold_left      = 0;
    int              quiet_cycles   = 0;

    logic [1:0] phase_policy [0:PHASES-1] = '{
        porq_pkg::POL_FIFO, porq_pkg::POL_RFF, porq_pkg::POL_SFF, POL_UNUSED,
        porq_pkg::POL_RFF, porq_pkg::POL_SFF, porq_pkg::POL_FIFO, porq_pkg::POL_RFF,
        porq_pkg::POL_SFF, porq_pkg::POL_FIFO, porq_pkg::POL_RFF, porq_pkg::POL_SFF,
        porq_pkg::POL_RFF, porq_pkg::POL_SFF, porq_pkg::POL_FIFO, porq_pkg::POL_SFF
    };
    logic [4:0] phase_capacity [0:PHASES-1] = '{
        5'd16, 5'd16, 5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd8,
        5'd17, 5'd2, 5'd16, 5'd16, 5'd3, 5'd16, 5'd16, 5'd5
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sender_idle_pct();
        if (idle_mode == MODE_SENDER) return 68;
        if (idle_mode == MODE_BOTH) return 11;
        return 0;
    endfunction

    function automatic int recv_stall_pct();
        if (idle_mode == MODE_RECV) return 68;
        if (idle_mode == MODE_BOTH) return 11;
        return 0;
    endfunction

    function automatic logic [31:0] random_key();
        case ($urandom_range(3))
            0: random_key = $urandom_range(3);
            1: random_key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: random_key = $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.payload);
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else if (stall_requests != stall_served) begin
            rsp_if.ready <= 1'b0;
            hold_left = LONG_HOLD;
            stall_served++;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct());
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles.", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input porq_pkg::t_req r);
        while ($urandom_range(99) < sender_idle_pct()) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic enqueue(input logic [15:0] id, input logic [31:0] t, input logic [31:0] s);
        porq_pkg::t_req r;
        r.req_type      = porq_pkg::REQ_ENQ;
        r.request_id    = id;
        r.modified_time = t;
        r.item_size     = s;
        send_request(r);
    endtask

    task automatic dequeue();
        porq_pkg::t_req r;
        r.req_type      = porq_pkg::REQ_DEQ;
        r.request_id    = $urandom_range(16'hFFFF);
        r.modified_time = $urandom;
        r.item_size     = $urandom;
        send_request(r);
    endtask

    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (sb.pending_rsps.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic configure(input logic idx, input logic [4:0] data);
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_register(idx, data);
    endtask

    task automatic run_directed();
        dequeue();
        enqueue(16'h0000, 32'h0000_0000, 32'h0000_0000);
        enqueue(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        enqueue(16'h0001, 32'd5, 32'd9);
        enqueue(16'h0002, 32'd5, 32'd9);
        enqueue(16'h0003, 32'd1, 32'd1);
        dequeue();

        // Capacity drops to zero below the current occupancy.
        configure(porq_pkg::CFG_CAPACITY, 5'd0);
        enqueue(16'h0004, 32'd2, 32'd2);
        dequeue();
        dequeue();
        dequeue();
        enqueue(16'h0005, 32'd3, 32'd3);

        configure(porq_pkg::CFG_POLICY, {3'b000, porq_pkg::POL_RFF});
        configure(porq_pkg::CFG_CAPACITY, 5'd31);
        enqueue(16'h0010, 32'd100, 32'd7);
        enqueue(16'h0011, 32'd100, 32'd7);
        enqueue(16'h0012, 32'hFFFF_FFFF, 32'd7);
        enqueue(16'h0013, 32'd0, 32'd7);

        // The policy changes while entries remain queued.
        configure(porq_pkg::CFG_POLICY, {3'b000, porq_pkg::POL_SFF});
        enqueue(16'h0020, 32'd1, 32'd50);
        enqueue(16'h0021, 32'd1, 32'd50);
        enqueue(16'h0022, 32'd1, 32'd0);

        configure(porq_pkg::CFG_POLICY, {3'b000, POL_UNUSED});
        enqueue(16'h0030, 32'hFFFF_FFFF, 32'h0);
        dequeue();
        dequeue();
    endtask

    task automatic run_phase(input int p);
        int             enq_pct;
        int             n;
        porq_pkg::t_req r;
        configure(porq_pkg::CFG_POLICY, {3'b000, phase_policy[p]});
        configure(porq_pkg::CFG_CAPACITY, phase_capacity[p]);
        idle_mode = p % 4;
        enq_pct   = $urandom_range(35, 75);
        if (p == 4 || p == 10)
            stall_requests++;
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2 && p % 3 == 0)
                wait_for_drain();
            r.req_type      = ($urandom_range(99) < enq_pct) ? porq_pkg::REQ_ENQ
                                                             : porq_pkg::REQ_DEQ;
            r.request_id    = $urandom_range(16'hFFFF);
            r.modified_time = random_key();
            r.item_size     = random_key();
            send_request(r);
        end
    endtask

    initial begin
        int p;
        sb             = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= porq_pkg::CFG_POLICY;
        i_cfg_data     <= 5'd0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (p = 0; p < PHASES; p++)
            run_phase(p);

        wait_for_drain();
        repeat (5) @(posedge i_clk);
        $display("Checked %0d request transactions over %0d policy/capacity settings.",
                 sb.n_requests, PHASES + 4);
        $display("Rejected enqueues: %0d, dequeues on empty: %0d, ids removed: %0d.",
                 sb.n_rejected, sb.n_empty_deq, sb.n_removed);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
